// File: src/ecg_derived_respiration_tracker_defines.svh
// Assertion macros for the respiration tracker.
// Depends on clk_i and rst_ni in the module that includes this file.
`ifndef ECG_DERIVED_RESPIRATION_TRACKER_DEFINES_SVH
`define ECG_DERIVED_RESPIRATION_TRACKER_DEFINES_SVH

// checked outside reset
`define EDR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("edr check failed");

// checked at every edge
`define EDR_ASSERT_ALL(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("edr check failed");

`endif

// File: src/edr_pkg.sv
// Shared types, constants and helpers of the respiration tracker.
// No dependencies.
package edr_pkg;

  localparam int unsigned AMP_BITS    = 40;
  localparam int unsigned ANG_BITS    = 24;
  localparam int unsigned OUT_BITS    = 18;
  localparam int unsigned AREA_BITS   = 24;
  localparam int unsigned CW          = 49;
  localparam int unsigned CORD_W      = 36;
  localparam int unsigned Z_W         = 25;
  localparam int unsigned CORDIC_STEPS = 21;
  localparam int unsigned COUNT_LIMIT_DEF = 500;

  localparam logic signed [CW-1:0] AMP_ONE    = CW'(65536);
  localparam logic signed [CW-1:0] ANG_FLOOR  = CW'(1049);
  localparam logic signed [CW-1:0] ANG_PI     = CW'(3294199);
  localparam logic signed [CW-1:0] ANG_TWO_PI = CW'(6588397);
  localparam logic signed [Z_W-1:0] ZPI       = Z_W'(3294199);
  localparam logic signed [Z_W-1:0] ZHALF_PI  = Z_W'(1647099);

  localparam logic [1:0] CH_X = 2'd0;
  localparam logic [1:0] CH_Y = 2'd1;
  localparam logic [1:0] CH_A = 2'd2;

  localparam logic [1:0] LEAD_ONE = 2'd1;
  localparam logic [1:0] LEAD_RST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_CNT, S_DN, S_DEV, S_LIM, S_CORD_INIT, S_CORD,
    S_ANG, S_FIN, S_OUT, S_DIV, S_DONE
  } state_e;

  function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
    logic signed [Z_W-1:0] r;
    unique case (i)
      5'd0: r = Z_W'(823550);
      5'd1: r = Z_W'(486170);
      5'd2: r = Z_W'(256879);
      5'd3: r = Z_W'(130396);
      5'd4: r = Z_W'(65451);
      5'd5: r = Z_W'(32757);
      5'd6: r = Z_W'(16383);
      default: r = (i <= 5'd20) ? (Z_W'(8192) >>> (i - 5'd7)) : '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [CW-1:0] sat_w(input logic signed [CW-1:0] v,
                                                   input int unsigned bits);
    logic signed [CW-1:0] hi, lo;
    hi = $signed((CW'(1) << (bits - 1)) - CW'(1));
    lo = -hi - CW'(1);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

// File: src/ecg_derived_respiration_tracker.sv
// Top level of the ECG-derived respiration tracker: trackers, serial divider, CORDIC.
// Depends on edr_pkg and ecg_derived_respiration_tracker_defines.svh.
//
//  channel | signals                               | direction
//  in      | in_valid_i in_stall_o x/y_area_i      | beat in
//  out     | out_valid_o out_stall_i edr_value_o   | beat out
//  cfg     | cfg_valid_i cfg_ready_o cfg_data_i    | lead_count write
//
// One beat at a time. A beat with both areas zero goes straight to the done state and
// gives a zero result; otherwise each tracker step runs three bit-serial divisions on
// the shared restoring divider (one quotient bit per cycle), and a final division ends
// the beat: in two-lead mode it follows the X and Y steps, a 21-step CORDIC and the angle
// step, in one-lead mode only the X step. The block returns to idle before the next
// accept. Reset clears all tracker state and sets lead_count to 2. A stalled earlier
// result holds the block in its done state until taken.
`include "ecg_derived_respiration_tracker_defines.svh"
module ecg_derived_respiration_tracker #(
  parameter int unsigned COUNT_LIMIT = edr_pkg::COUNT_LIMIT_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [edr_pkg::AREA_BITS-1:0]   x_area_i,
  input  logic signed [edr_pkg::AREA_BITS-1:0]   y_area_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [edr_pkg::OUT_BITS-1:0]    edr_value_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [1:0]                             cfg_data_i
);
  import edr_pkg::*;

  localparam int unsigned CNT_W = $clog2(COUNT_LIMIT + 1);
  localparam int unsigned DC_W  = $clog2(CW);

  state_e state_q, state_d, ret_q;
  logic [1:0] ch_q, lead_q;
  logic signed [AREA_BITS-1:0] xa_q, ya_q;
  logic signed [AMP_BITS-1:0] mean_q [3];
  logic signed [AMP_BITS-1:0] dev_q [3];
  logic signed [AMP_BITS-1:0] lim_q [3];
  logic [CNT_W-1:0] cnt_q [3];
  logic signed [CW-1:0] d_q, res_q, dn_q;
  logic atlim_q;
  logic [CW-1:0] quo_q, dvs_q;
  logic [CW:0] rem_q;
  logic neg_q;
  logic [DC_W-1:0] dcnt_q;
  logic signed [CORD_W-1:0] cx_q, cy_q;
  logic signed [Z_W-1:0] cz_q;
  logic [4:0] ci_q;
  logic signed [OUT_BITS-1:0] pend_q, out_q;
  logic out_valid_q;

  logic accept, both_zero, div_start, div_last, cord_last;
  logic [CW:0] rem_sh;
  logic rem_ge;
  logic signed [CW-1:0] quot, div_a, div_b;
  logic [CNT_W-1:0] cnt_cur, cnt_inc;
  logic signed [CW-1:0] lim_cur, dev_cur, mean_cur, dn_cl, adn, dev_sat, dev_new;
  logic signed [CW-1:0] mean_sum, mean_new, dev_floor, theta, da, d_next;
  logic signed [CW-1:0] lim_sat, out_sat;
  int unsigned bits;
  logic signed [CORD_W-1:0] sx, sy;

  assign accept    = in_valid_i && !in_stall_o;
  assign both_zero = (x_area_i == '0) && (y_area_i == '0);
  assign div_last  = (dcnt_q == DC_W'(CW - 1));
  assign cord_last = (ci_q == 5'(CORDIC_STEPS - 1));

  always_comb begin
    cnt_cur   = cnt_q[ch_q];
    cnt_inc   = (cnt_cur < CNT_W'(COUNT_LIMIT)) ? cnt_cur + CNT_W'(1) : cnt_cur;
    quot      = neg_q ? -$signed(quo_q) : $signed(quo_q);
    lim_cur   = CW'(lim_q[ch_q]);
    dev_cur   = CW'(dev_q[ch_q]);
    mean_cur  = CW'(mean_q[ch_q]);
    bits      = (ch_q == CH_A) ? ANG_BITS : AMP_BITS;
    dev_floor = (ch_q == CH_A) ? ANG_FLOOR : AMP_ONE;
    if (atlim_q && quot > lim_cur) dn_cl = lim_cur;
    else if (atlim_q && quot < -lim_cur) dn_cl = -lim_cur;
    else dn_cl = quot;
    adn      = (dn_q < 0) ? -dn_q : dn_q;
    dev_sat  = sat_w(dev_cur + adn - quot, bits);
    dev_new  = (dev_sat < dev_floor) ? dev_floor : dev_sat;
    mean_sum = mean_cur + dn_q;
    if (ch_q == CH_A) begin
      if (mean_sum > ANG_PI) mean_sum = mean_sum - ANG_TWO_PI;
      else if (mean_sum < -ANG_PI) mean_sum = mean_sum + ANG_TWO_PI;
    end
    mean_new = sat_w(mean_sum, bits);
    lim_sat  = sat_w(quot, bits);
    out_sat  = sat_w(quot, OUT_BITS);
    if (cz_q > ZPI) theta = CW'(ZPI);
    else if (cz_q < -ZPI) theta = -CW'(ZPI);
    else theta = CW'(cz_q);
    da = theta - CW'(mean_q[CH_A]);
    if (da > ANG_PI) da = da - ANG_TWO_PI;
    else if (da < -ANG_PI) da = da + ANG_TWO_PI;
    d_next = (CW'(ya_q) <<< 16) - CW'(mean_q[CH_Y]);
    sx = cx_q >>> ci_q;
    sy = cy_q >>> ci_q;
    rem_sh = {rem_q[CW-1:0], quo_q[CW-1]};
    rem_ge = rem_sh >= {1'b0, dvs_q};
  end

  always_comb begin
    div_start = 1'b0;
    div_a     = d_q;
    div_b     = CW'(cnt_inc);
    unique case (state_q)
      S_CNT: div_start = 1'b1;
      S_DN: begin
        div_start = 1'b1;
        div_a     = dev_cur;
        div_b     = CW'(cnt_cur);
      end
      S_DEV: begin
        div_start = 1'b1;
        div_a     = dev_new + (dev_new <<< 1);
        div_b     = CW'(cnt_cur);
      end
      S_FIN: begin
        div_start = 1'b1;
        div_a     = (res_q <<< 5) + (res_q <<< 4) + (res_q <<< 1);
        div_b     = dev_cur;
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:      if (accept) state_d = both_zero ? S_DONE : S_CNT;
      S_CNT:       state_d = S_DIV;
      S_DN:        state_d = S_DIV;
      S_DEV:       state_d = S_DIV;
      S_LIM: begin
        if (ch_q == CH_X) state_d = (lead_q == LEAD_ONE) ? S_FIN : S_CNT;
        else if (ch_q == CH_Y) state_d = S_CORD_INIT;
        else state_d = S_FIN;
      end
      S_CORD_INIT: state_d = S_CORD;
      S_CORD:      if (cord_last) state_d = S_ANG;
      S_ANG:       state_d = S_CNT;
      S_FIN:       state_d = S_DIV;
      S_OUT:       state_d = S_DONE;
      S_DIV:       if (div_last) state_d = ret_q;
      S_DONE:      if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != S_IDLE);
    cfg_ready_o = 1'b1;
    out_valid_o = out_valid_q;
    edr_value_o = out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ret_q       <= S_IDLE;
      lead_q      <= LEAD_RST;
      out_valid_q <= 1'b0;
      ch_q        <= CH_X;
      for (int k = 0; k < 3; k++) begin
        mean_q[k] <= '0;
        dev_q[k]  <= '0;
        lim_q[k]  <= '0;
        cnt_q[k]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) lead_q <= cfg_data_i;
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) out_valid_q <= 1'b1;
      else if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (div_start) begin
        quo_q  <= (div_a < 0) ? $unsigned(-div_a) : $unsigned(div_a);
        neg_q  <= div_a < 0;
        dvs_q  <= $unsigned(div_b);
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      unique case (state_q)
        S_IDLE: if (accept) begin
          xa_q   <= x_area_i;
          ya_q   <= y_area_i;
          pend_q <= '0;
          ch_q   <= CH_X;
          d_q    <= (CW'(x_area_i) <<< 16) - CW'(mean_q[CH_X]);
          res_q  <= (CW'(x_area_i) <<< 16) - CW'(mean_q[CH_X]);
        end
        S_CNT: begin
          atlim_q     <= cnt_cur >= CNT_W'(COUNT_LIMIT);
          cnt_q[ch_q] <= cnt_inc;
          ret_q       <= S_DN;
        end
        S_DN: begin
          dn_q  <= dn_cl;
          ret_q <= S_DEV;
        end
        S_DEV: begin
          dev_q[ch_q]  <= dev_new[AMP_BITS-1:0];
          mean_q[ch_q] <= mean_new[AMP_BITS-1:0];
          ret_q        <= S_LIM;
        end
        S_LIM: begin
          lim_q[ch_q] <= lim_sat[AMP_BITS-1:0];
          if (ch_q == CH_X && lead_q != LEAD_ONE) begin
            ch_q <= CH_Y;
            d_q  <= d_next;
          end
        end
        S_CORD_INIT: begin
          ci_q <= '0;
          if (ya_q < 0) begin
            if (xa_q >= 0) begin
              cx_q <= CORD_W'(xa_q) <<< 8;
              cy_q <= -(CORD_W'(ya_q) <<< 8);
              cz_q <= ZHALF_PI;
            end else begin
              cx_q <= -(CORD_W'(xa_q) <<< 8);
              cy_q <= CORD_W'(ya_q) <<< 8;
              cz_q <= -ZHALF_PI;
            end
          end else begin
            cx_q <= CORD_W'(ya_q) <<< 8;
            cy_q <= CORD_W'(xa_q) <<< 8;
            cz_q <= '0;
          end
        end
        S_CORD: begin
          ci_q <= ci_q + 5'd1;
          if (cy_q >= 0) begin
            cx_q <= cx_q + sy;
            cy_q <= cy_q - sx;
            cz_q <= cz_q + atan_lut(ci_q);
          end else begin
            cx_q <= cx_q - sy;
            cy_q <= cy_q + sx;
            cz_q <= cz_q - atan_lut(ci_q);
          end
        end
        S_ANG: begin
          ch_q  <= CH_A;
          d_q   <= da;
          res_q <= da;
        end
        S_FIN: ret_q <= S_OUT;
        S_DIV: begin
          rem_q  <= rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
          quo_q  <= {quo_q[CW-2:0], rem_ge};
          dcnt_q <= dcnt_q + DC_W'(1);
        end
        S_OUT: pend_q <= out_sat[OUT_BITS-1:0];
        S_DONE: if (!out_valid_q || !out_stall_i) begin
          out_q <= pend_q;
        end
        default: ;
      endcase
    end
  end

  `EDR_ASSERT(a_cnt_bound, (cnt_q[CH_X] <= CNT_W'(COUNT_LIMIT)))
  `EDR_ASSERT(a_dev_floor, (state_q == S_IDLE && cnt_q[CH_X] != '0) |-> (CW'(dev_q[CH_X]) >= AMP_ONE))
  `EDR_ASSERT(a_div_nonzero, (state_q == S_DIV) |-> (dvs_q != '0))
  `EDR_ASSERT_ALL(a_busy_stall, (state_q != S_IDLE) |-> in_stall_o)

endmodule
